[rtl/acp_pkg.sv]
// Shared types, widths and codes for the box collision and push-out block.
// No dependencies; imported by acp_table, acp_geom and the top level.
`default_nettype none

package acp_pkg;

  // Field widths
  localparam int W_COORD      = 16;
  localparam int W_EXT        = 18;  // coordinate plus size, with headroom for sign
  localparam int W_SIZE       = 12;
  localparam int W_TAG        = 3;
  localparam int W_SLOT       = 5;
  localparam int W_DIR        = 3;
  localparam int W_PAIRS      = 64;
  localparam int W_TRIG_CNT   = 6;
  localparam int MAX_TRIGGERS = 32;

  // Input function codes
  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_RESOLVE = 1'b1;

  // Result kinds
  localparam logic KIND_TRIGGER = 1'b0;
  localparam logic KIND_FINAL   = 1'b1;

  // Configuration register indexes
  localparam logic REG_PHYSICS = 1'b0;
  localparam logic REG_TRIGGER = 1'b1;

  // Push directions
  localparam logic [W_DIR-1:0] DIR_NONE  = 3'd0;
  localparam logic [W_DIR-1:0] DIR_LEFT  = 3'd1;
  localparam logic [W_DIR-1:0] DIR_RIGHT = 3'd2;
  localparam logic [W_DIR-1:0] DIR_UP    = 3'd3;
  localparam logic [W_DIR-1:0] DIR_DOWN  = 3'd4;

  // One box: position, size and tag
  typedef struct packed {
    logic signed [W_COORD-1:0] x;
    logic signed [W_COORD-1:0] y;
    logic [W_SIZE-1:0]         w;
    logic [W_SIZE-1:0]         h;
    logic [W_TAG-1:0]          tag;
  } box_t;

  // Geometry unit results: hit is valid in the test step,
  // the push fields in the push step
  typedef struct packed {
    logic                      hit;
    logic signed [W_COORD-1:0] new_x;
    logic signed [W_COORD-1:0] new_y;
    logic [W_DIR-1:0]          dir;
  } geom_res_t;

endpackage

`default_nettype wire

[rtl/acp_table.sv]
// Static box table: box data in a memory with registered read,
// valid bits in flip-flops cleared by reset. Uses acp_pkg.
`default_nettype none

module acp_table #(
  parameter int DEPTH = 32,
  parameter int IDX_W = 5
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_en,
  input  wire logic           wr_store,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire acp_pkg::box_t  wr_box,
  input  wire logic           rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output acp_pkg::box_t       rd_box,
  output logic                rd_valid
);
  import acp_pkg::*;

  box_t             mem [DEPTH];
  logic [DEPTH-1:0] valid_bits;

  // Box data memory; a removal only clears the valid bit
  always_ff @(posedge clk) begin
    if (wr_en && wr_store) begin
      mem[wr_addr] <= wr_box;
    end
    if (rd_en) begin
      rd_box <= mem[rd_addr];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (wr_en) begin
      valid_bits[wr_addr] <= wr_store;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_valid <= valid_bits[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/acp_geom.sv]
// Shared geometry unit: strict overlap test and penetration depths in the
// test step, least-depth push-out with saturation in the push step. Uses acp_pkg.
`default_nettype none

module acp_geom (
  input  wire logic          clk,
  input  wire logic          capture,
  input  wire acp_pkg::box_t mov,
  input  wire acp_pkg::box_t stat,
  output acp_pkg::geom_res_t res
);
  import acp_pkg::*;

  localparam logic signed [W_EXT-1:0] SAT_HI = 18'sd32767;
  localparam logic signed [W_EXT-1:0] SAT_LO = -18'sd32768;

  logic signed [W_EXT-1:0] mx, my, mw, mh, mr, mb;
  logic signed [W_EXT-1:0] sx, sy, sw, sh, sr, sb;
  logic signed [W_EXT-1:0] depth [4];
  logic signed [W_EXT-1:0] cand [4];

  function automatic logic signed [W_COORD-1:0] sat16(input logic signed [W_EXT-1:0] v);
    logic signed [W_COORD-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[W_COORD-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[W_COORD-1:0];
    end else begin
      r = v[W_COORD-1:0];
    end
    return r;
  endfunction

  // Edges of both boxes
  always_comb begin
    mx = W_EXT'(mov.x);
    my = W_EXT'(mov.y);
    mw = W_EXT'(mov.w);
    mh = W_EXT'(mov.h);
    sx = W_EXT'(stat.x);
    sy = W_EXT'(stat.y);
    sw = W_EXT'(stat.w);
    sh = W_EXT'(stat.h);
    mr = mx + mw;
    mb = my + mh;
    sr = sx + sw;
    sb = sy + sh;
  end

  // Depths and candidate positions for the push step
  always_ff @(posedge clk) begin
    if (capture) begin
      depth[0] <= mr - sx;
      depth[1] <= sr - mx;
      depth[2] <= mb - sy;
      depth[3] <= sb - my;
      cand[0]  <= sx - mw;
      cand[1]  <= sr;
      cand[2]  <= sy - mh;
      cand[3]  <= sb;
    end
  end

  // Strict overlap; least depth, first wins on ties, then saturated push
  always_comb begin
    logic [1:0]              best;
    logic signed [W_EXT-1:0] bd;
    res.hit = !((sx >= mr) || (sr <= mx) || (sy >= mb) || (sb <= my));
    best = 2'd0;
    bd   = depth[0];
    if (depth[1] < bd) begin
      best = 2'd1;
      bd   = depth[1];
    end
    if (depth[2] < bd) begin
      best = 2'd2;
      bd   = depth[2];
    end
    if (depth[3] < bd) begin
      best = 2'd3;
    end
    res.new_x = mov.x;
    res.new_y = mov.y;
    case (best)
      2'd0: begin
        res.new_x = sat16(cand[0]);
        res.dir   = DIR_LEFT;
      end
      2'd1: begin
        res.new_x = sat16(cand[1]);
        res.dir   = DIR_RIGHT;
      end
      2'd2: begin
        res.new_y = sat16(cand[2]);
        res.dir   = DIR_UP;
      end
      default: begin
        res.new_y = sat16(cand[3]);
        res.dir   = DIR_DOWN;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/aabb_collide_and_push_out.sv]
// Box collision and push-out: top level with the walk sequencer.
// Instantiates acp_table and acp_geom; uses acp_pkg.
//
// A load transfer writes or removes one static box and gives no result. A
// resolve transfer walks all NUM_STATICS table slots in order; each slot has a
// registered table read, then the overlap test in the shared geometry unit,
// plus a push-out step and a trigger event step where they apply, and the
// final result follows the walk. Trigger events and the final result wait
// while the output stalls.
// The walk is serial because each push moves the box used by the next test.
// in_ready is high only while no resolve is running; a waiting result does not
// block the next transfer. Reset clears the valid bits at once.
`default_nettype none

module aabb_collide_and_push_out #(
  parameter int NUM_STATICS = 32,
  parameter int NUM_TAGS    = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [63:0]       cfg_data,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              func,
  input  wire logic [4:0]        slot,
  input  wire logic signed [15:0] pos_x,
  input  wire logic signed [15:0] pos_y,
  input  wire logic [11:0]       width,
  input  wire logic [11:0]       height,
  input  wire logic [2:0]        tag,
  input  wire logic              entry_valid,
  // output channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   kind,
  output logic [4:0]             hit_slot,
  output logic signed [15:0]     out_x,
  output logic signed [15:0]     out_y,
  output logic [2:0]             direction,
  output logic                   last
);
  import acp_pkg::*;

  localparam int IDX_W = (NUM_STATICS > 1) ? $clog2(NUM_STATICS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_STATICS - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_TEST  = 6'b000100,
    S_PUSH  = 6'b001000,
    S_EMIT  = 6'b010000,
    S_FINAL = 6'b100000
  } state_t;

  state_t               state;
  logic [IDX_W-1:0]     idx;
  box_t                 mov;
  logic [W_DIR-1:0]     dir;
  logic [W_TRIG_CNT-1:0] trig_cnt;
  logic                 do_trig;
  logic [W_PAIRS-1:0]   physics_pairs;
  logic [W_PAIRS-1:0]   trigger_pairs;

  logic      in_xfer, out_free, out_load, idx_last;
  logic      wr_en;
  box_t      in_box, rd_box;
  logic      rd_valid;
  geom_res_t geom;
  logic      tags_ok, hit, phys_on, trig_on;
  logic [5:0] pair_idx;

  assign in_ready = (state == S_IDLE) && !rst;
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign idx_last = (idx == LAST_IDX);

  // Output register loads from the emit and final steps
  assign out_load = out_free && ((state == S_EMIT) || (state == S_FINAL));

  assign in_box.x   = pos_x;
  assign in_box.y   = pos_y;
  assign in_box.w   = width;
  assign in_box.h   = height;
  assign in_box.tag = tag;

  // Loads beyond the table are dropped
  assign wr_en = in_xfer && (func == FUNC_LOAD) && (int'(slot) < NUM_STATICS);

  acp_table #(
    .DEPTH (NUM_STATICS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_store (entry_valid),
    .wr_addr  (IDX_W'(slot)),
    .wr_box   (in_box),
    .rd_en    (state == S_READ),
    .rd_addr  (idx),
    .rd_box   (rd_box),
    .rd_valid (rd_valid)
  );

  acp_geom u_geom (
    .clk     (clk),
    .capture (state == S_TEST),
    .mov     (mov),
    .stat    (rd_box),
    .res     (geom)
  );

  // Tag pair lookup for the slot under test
  always_comb begin
    pair_idx = {mov.tag, rd_box.tag};
    tags_ok  = (int'(mov.tag) < NUM_TAGS) && (int'(rd_box.tag) < NUM_TAGS);
    hit      = rd_valid && geom.hit;
    phys_on  = tags_ok && physics_pairs[pair_idx];
    trig_on  = tags_ok && trigger_pairs[pair_idx] &&
               (trig_cnt < W_TRIG_CNT'(MAX_TRIGGERS));
  end

  // Sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      physics_pairs <= '0;
      trigger_pairs <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PHYSICS: physics_pairs <= cfg_data;
          REG_TRIGGER: trigger_pairs <= cfg_data;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_xfer && (func == FUNC_RESOLVE)) begin
            mov      <= in_box;
            dir      <= DIR_NONE;
            trig_cnt <= '0;
            idx      <= '0;
            state    <= S_READ;
          end
        end
        S_READ: begin
          state <= S_TEST;
        end
        S_TEST: begin
          do_trig <= trig_on;
          if (hit && phys_on) begin
            state <= S_PUSH;
          end else if (hit && trig_on) begin
            state <= S_EMIT;
          end else if (idx_last) begin
            state <= S_FINAL;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_READ;
          end
        end
        S_PUSH: begin
          mov.x <= geom.new_x;
          mov.y <= geom.new_y;
          dir   <= geom.dir;
          if (do_trig) begin
            state <= S_EMIT;
          end else if (idx_last) begin
            state <= S_FINAL;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_READ;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            kind      <= KIND_TRIGGER;
            hit_slot  <= W_SLOT'(idx);
            out_x     <= mov.x;
            out_y     <= mov.y;
            direction <= dir;
            last      <= 1'b0;
            trig_cnt  <= trig_cnt + 1'b1;
            if (idx_last) begin
              state <= S_FINAL;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_READ;
            end
          end
        end
        S_FINAL: begin
          if (out_free) begin
            kind      <= KIND_FINAL;
            hit_slot  <= '0;
            out_x     <= mov.x;
            out_y     <= mov.y;
            direction <= dir;
            last      <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[verif/tb_aabb_collide_and_push_out.sv]
`timescale 1ns / 1ps
// Self-checking testbench for aabb_collide_and_push_out: directed edge cases, then random
// load and resolve traffic under several pair-mask settings, checked against an in-bench model.
// Depends on acp_pkg and the RTL top level; needs no files or arguments.
module tb_aabb_collide_and_push_out;
  import acp_pkg::*;

  localparam int NUM_SLOTS     = 32;
  localparam int NUM_TAG_VALS  = 8;
  localparam int SETTLE_CYCLES = 150;   // a full walk plus margin
  localparam int LONG_HOLD     = 400;
  localparam int TIMEOUT_NS    = 2_000_000;

  // One input transfer
  typedef struct {
    logic                      func;
    logic [W_SLOT-1:0]         slot;
    logic signed [W_COORD-1:0] x;
    logic signed [W_COORD-1:0] y;
    logic [W_SIZE-1:0]         w;
    logic [W_SIZE-1:0]         h;
    logic [W_TAG-1:0]          tag;
    logic                      ev;
  } box_item_t;

  // One output transfer
  typedef struct {
    logic                      kind;
    logic [W_SLOT-1:0]         hit_slot;
    logic signed [W_COORD-1:0] x;
    logic signed [W_COORD-1:0] y;
    logic [W_DIR-1:0]          dir;
    logic                      last;
  } push_result_t;

  // Static box table, pair masks and the queue of results still owed by the block
  class push_out_scoreboard;
    int                bx[NUM_SLOTS];
    int                by[NUM_SLOTS];
    int                bw[NUM_SLOTS];
    int                bh[NUM_SLOTS];
    logic [W_TAG-1:0]  btag[NUM_SLOTS];
    bit                bvalid[NUM_SLOTS];
    logic [63:0]       physics_mask;
    logic [63:0]       trigger_mask;
    push_result_t      expected_results[$];
    int                errors;

    function new();
      for (int i = 0; i < NUM_SLOTS; i++) bvalid[i] = 1'b0;
      physics_mask = '0;
      trigger_mask = '0;
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [63:0] data);
      if (idx == REG_PHYSICS) physics_mask = data;
      else trigger_mask = data;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function bit pair_on(logic [63:0] mask, logic [W_TAG-1:0] mtag, logic [W_TAG-1:0] stag);
      if (int'(mtag) >= NUM_TAG_VALS || int'(stag) >= NUM_TAG_VALS) return 1'b0;
      return mask[int'(mtag) * 8 + int'(stag)];
    endfunction

    function int clamp16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function void owe_result(logic k, int s, int x, int y, logic [W_DIR-1:0] dir);
      push_result_t r;
      r.kind     = k;
      r.hit_slot = s[W_SLOT-1:0];
      r.x        = x[W_COORD-1:0];
      r.y        = y[W_COORD-1:0];
      r.dir      = dir;
      r.last     = (k == KIND_FINAL);
      expected_results.push_back(r);
    endfunction

    // Accepted input: update the table, or walk it and queue the results
    function void note_item(box_item_t it);
      int x, y, w, h, best, i, k;
      int depth[4];
      logic [W_DIR-1:0] dir;
      if (it.func == FUNC_LOAD) begin
        if (int'(it.slot) < NUM_SLOTS) begin
          if (it.ev) begin
            bx[it.slot]     = it.x;
            by[it.slot]     = it.y;
            bw[it.slot]     = it.w;
            bh[it.slot]     = it.h;
            btag[it.slot]   = it.tag;
            bvalid[it.slot] = 1'b1;
          end else begin
            bvalid[it.slot] = 1'b0;
          end
        end
        return;
      end
      x = it.x;
      y = it.y;
      w = it.w;
      h = it.h;
      dir = DIR_NONE;
      for (i = 0; i < NUM_SLOTS; i++) begin
        if (!bvalid[i]) continue;
        // strict overlap, against the box as moved so far
        if (bx[i] >= x + w || bx[i] + bw[i] <= x || by[i] >= y + h || by[i] + bh[i] <= y)
          continue;
        if (pair_on(physics_mask, it.tag, btag[i])) begin
          depth[0] = x + w - bx[i];
          depth[1] = bx[i] + bw[i] - x;
          depth[2] = y + h - by[i];
          depth[3] = by[i] + bh[i] - y;
          best = 0;
          for (k = 1; k < 4; k++)
            if (depth[k] < depth[best]) best = k;
          case (best)
            0: begin
              x = clamp16(bx[i] - w);
              dir = DIR_LEFT;
            end
            1: begin
              x = clamp16(bx[i] + bw[i]);
              dir = DIR_RIGHT;
            end
            2: begin
              y = clamp16(by[i] - h);
              dir = DIR_UP;
            end
            default: begin
              y = clamp16(by[i] + bh[i]);
              dir = DIR_DOWN;
            end
          endcase
        end
        if (pair_on(trigger_mask, it.tag, btag[i])) owe_result(KIND_TRIGGER, i, x, y, dir);
      end
      owe_result(KIND_FINAL, 0, x, y, dir);
    endfunction

    function void compare_field(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Accepted result: compare with the oldest owed one
    function void check_result(push_result_t got);
      push_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %0d slot %0d x %0d y %0d",
                 $time, got.kind, got.hit_slot, got.x, got.y);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("hit_slot", want.hit_slot, got.hit_slot);
      compare_field("out_x", want.x, got.x);
      compare_field("out_y", want.y, got.y);
      compare_field("direction", want.dir, got.dir);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic                      cfg_index = 1'b0;
  logic [63:0]               cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      func = 1'b0;
  logic [4:0]                slot = '0;
  logic signed [15:0]        pos_x = '0;
  logic signed [15:0]        pos_y = '0;
  logic [11:0]               width = '0;
  logic [11:0]               height = '0;
  logic [2:0]                tag = '0;
  logic                      entry_valid = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      kind;
  logic [4:0]                hit_slot;
  logic signed [15:0]        out_x;
  logic signed [15:0]        out_y;
  logic [2:0]                direction;
  logic                      last;

  bit                        tx_fast = 1'b0;
  bit                        rx_fast = 1'b0;
  int                        rx_hold = 0;
  push_out_scoreboard        sb;

  aabb_collide_and_push_out u_top (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop
  initial begin
    #(TIMEOUT_NS);
    $display("end of test: mismatches");
    $finish;
  end

  // Result side: random stalls, occasional long hold-off
  initial begin
    int stall;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      if ($urandom_range(0, 29) == 0) rx_fast = !rx_fast;
      stall = rx_fast ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(push_result_t'{kind, hit_slot, out_x, out_y, direction, last});
  end

  function automatic box_item_t mk_item(logic f, int s, int x, int y, int w, int h, int t,
                                        logic ev);
    box_item_t it;
    it.func = f;
    it.slot = s[W_SLOT-1:0];
    it.x    = x[W_COORD-1:0];
    it.y    = y[W_COORD-1:0];
    it.w    = w[W_SIZE-1:0];
    it.h    = h[W_SIZE-1:0];
    it.tag  = t[W_TAG-1:0];
    it.ev   = ev;
    return it;
  endfunction

  // Mostly boxes in a small cluster so resolves hit; some removals and raw noise
  function automatic box_item_t random_item();
    box_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it = mk_item(FUNC_RESOLVE, $urandom_range(0, NUM_SLOTS - 1),
                 int'($urandom_range(0, 600)) - 300, int'($urandom_range(0, 600)) - 300,
                 ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 160),
                 ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 160),
                 $urandom_range(0, 7), 1'b1);
    if (pick < 20) begin
      it.func = FUNC_LOAD;
    end else if (pick < 27) begin
      it.func = FUNC_LOAD;
      it.ev = 1'b0;
    end else if (pick < 37) begin
      it.func = 1'($urandom);
      it.slot = W_SLOT'($urandom);
      it.x    = W_COORD'($urandom);
      it.y    = W_COORD'($urandom);
      it.w    = W_SIZE'($urandom);
      it.h    = W_SIZE'($urandom);
      it.tag  = W_TAG'($urandom);
      it.ev   = 1'($urandom);
    end
    return it;
  endfunction

  task automatic write_reg(logic idx, logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  // One input transfer after a random gap; valid stays up across back-to-back items
  task automatic send_item(box_item_t it);
    int gap;
    if ($urandom_range(0, 24) == 0) tx_fast = !tx_fast;
    gap = tx_fast ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= it.func;
    slot        <= it.slot;
    pos_x       <= it.x;
    pos_y       <= it.y;
    width       <= it.w;
    height      <= it.h;
    tag         <= it.tag;
    entry_valid <= it.ev;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
  endtask

  // Stop sending until every owed result is in, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(logic [63:0] phys, logic [63:0] trig, int n_items, bit hold);
    box_item_t it;
    write_reg(REG_PHYSICS, phys);
    write_reg(REG_TRIGGER, trig);
    if (hold) rx_hold = LONG_HOLD;
    // refill part of the table first
    repeat (6) begin
      it = random_item();
      it.func = FUNC_LOAD;
      it.ev = 1'b1;
      send_item(it);
    end
    repeat (n_items) send_item(random_item());
    drain();
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: moving tag 7 has no push-out pairs, every pair triggers
    write_reg(REG_PHYSICS, 64'h00FF_FFFF_FFFF_FFFF);
    write_reg(REG_TRIGGER, '1);
    // identical boxes: all four depths tie, left wins
    send_item(mk_item(FUNC_LOAD, 0, 0, 0, 10, 10, 0, 1'b1));
    send_item(mk_item(FUNC_RESOLVE, 0, 0, 0, 10, 10, 0, 1'b1));
    // physics bit clear: trigger only, direction stays none
    send_item(mk_item(FUNC_RESOLVE, 0, 0, 0, 10, 10, 7, 1'b1));
    // zero-size moving box strictly inside the static one
    send_item(mk_item(FUNC_RESOLVE, 0, 5, 5, 0, 0, 1, 1'b1));
    // removal with junk in the other fields, then nothing to hit
    send_item(mk_item(FUNC_LOAD, 0, -1, -1, 4095, 4095, 7, 1'b0));
    send_item(mk_item(FUNC_RESOLVE, 31, 0, 0, 10, 10, 0, 1'b1));
    // left push saturates low
    send_item(mk_item(FUNC_LOAD, 31, -28674, 0, 100, 100, 2, 1'b1));
    send_item(mk_item(FUNC_RESOLVE, 0, -32768, 0, 4095, 100, 3, 1'b1));
    send_item(mk_item(FUNC_LOAD, 31, 0, 0, 0, 0, 0, 1'b0));
    // right push saturates high
    send_item(mk_item(FUNC_LOAD, 16, 28700, 0, 4095, 100, 4, 1'b1));
    send_item(mk_item(FUNC_RESOLVE, 0, 32767, 0, 10, 100, 5, 1'b1));
    send_item(mk_item(FUNC_LOAD, 16, 0, 0, 0, 0, 0, 1'b0));
    // up push saturates low
    send_item(mk_item(FUNC_LOAD, 5, 0, -28674, 100, 100, 6, 1'b1));
    send_item(mk_item(FUNC_RESOLVE, 0, 0, -32768, 100, 4095, 1, 1'b1));
    send_item(mk_item(FUNC_LOAD, 5, 0, 0, 0, 0, 0, 1'b0));
    // down push saturates high
    send_item(mk_item(FUNC_LOAD, 7, 0, 28700, 100, 4095, 0, 1'b1));
    send_item(mk_item(FUNC_RESOLVE, 0, 0, 32767, 100, 10, 2, 1'b1));
    send_item(mk_item(FUNC_LOAD, 7, 0, 0, 0, 0, 0, 1'b0));
    // right and down tie (right wins); the moved box then hits slot 10
    send_item(mk_item(FUNC_LOAD, 9, 0, 0, 20, 20, 3, 1'b1));
    send_item(mk_item(FUNC_LOAD, 10, 20, 0, 10, 40, 3, 1'b1));
    send_item(mk_item(FUNC_RESOLVE, 0, 10, 10, 20, 20, 3, 1'b1));
    drain();

    // Random phases over several mask settings, extremes included
    run_phase({$urandom, $urandom}, {$urandom, $urandom}, 55, 1'b1);
    run_phase('1, '0, 50, 1'b0);
    run_phase('0, '1, 50, 1'b0);
    run_phase('0, '0, 25, 1'b0);
    run_phase({$urandom, $urandom}, {$urandom, $urandom}, 60, 1'b0);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
